[hw/rtl/ecpe_pkg.sv]
package ecpe_pkg;

    localparam int PIX_W       = 8;
    localparam int IDX_W       = 16;
    localparam int BTH_W       = 24;
    localparam int CTH_W       = 7;
    localparam int FRM_W       = 17;
    localparam int ACC_INT_W   = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PIX  = 2'd2;

    localparam logic [BTH_W-1:0] BTH_RST = 24'd32768;
    localparam logic [CTH_W-1:0] CTH_RST = 7'd16;
    localparam logic [FRM_W-1:0] FRM_RST = 17'd65536;

    typedef struct packed {
        logic spike;
        logic on;
        logic off;
    } evt_t;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        evt_t             evt;
        logic             last;
    } res_t;

endpackage

[hw/rtl/ecpe_update.sv]
module ecpe_update #(
    parameter int ACC_W  = 24,
    parameter int FRAC_W = 8
) (
    input  logic [ecpe_pkg::PIX_W-1:0] pixel,
    input  logic [ACC_W-1:0]           acc_in,
    input  logic [ecpe_pkg::PIX_W-1:0] lvl_in,
    input  logic                       first,
    input  logic [ecpe_pkg::BTH_W-1:0] bth,
    input  logic [ecpe_pkg::CTH_W-1:0] cth,
    output logic [ACC_W-1:0]           acc_out,
    output logic [ecpe_pkg::PIX_W-1:0] lvl_out,
    output ecpe_pkg::evt_t             evt
);

    localparam int CMP_W = ((ACC_W > ecpe_pkg::BTH_W) ? ACC_W : ecpe_pkg::BTH_W) + 1;
    localparam int PIX_W = ecpe_pkg::PIX_W;

    logic [ACC_W-1:0] pix_fx;
    logic [ACC_W:0]   sum;
    logic [ACC_W-1:0] sat;
    logic [CMP_W-1:0] diff;
    logic             spike;
    logic [PIX_W:0]   up;
    logic [PIX_W-1:0] down;
    logic [PIX_W-1:0] cth_ext;
    logic             rise;
    logic             fall;

    assign pix_fx  = ACC_W'(pixel) << FRAC_W;
    assign sum     = {1'b0, acc_in} + {1'b0, pix_fx};
    assign sat     = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
    assign diff    = CMP_W'(sat) - CMP_W'(bth);
    assign spike   = ~diff[CMP_W-1];
    assign acc_out = spike ? diff[ACC_W-1:0] : sat;

    assign cth_ext = PIX_W'(cth);
    assign up      = {1'b0, lvl_in} + {1'b0, cth_ext};
    assign down    = lvl_in - cth_ext;
    assign rise    = {1'b0, pixel} >= up;
    assign fall    = !rise && (lvl_in >= cth_ext) && (pixel <= down);

    always_comb
    begin
        evt.spike = spike;
        evt.on    = 1'b0;
        evt.off   = 1'b0;
        lvl_out   = lvl_in;
        priority if (first)
        begin
            lvl_out = pixel;
        end
        else if (rise)
        begin
            evt.on  = 1'b1;
            lvl_out = up[PIX_W-1:0];
        end
        else if (fall)
        begin
            evt.off = 1'b1;
            lvl_out = down;
        end
        else
        begin
            lvl_out = lvl_in;
        end
    end

endmodule

[hw/rtl/event_camera_pixel_emulator_unit.sv]
// An accepted pixel passes the read registers (slot1_reg), the update registers
// (slot2_reg) and then the output register. Throughput: one pixel per cycle
// while in_stall is low; a same-pixel update closes through the write-back
// register, so any frame size sustains full rate. Reset: asynchronous, active low;
// a clearing pass then zeroes all MAX_PIXELS accumulator words, with in_stall high until it ends.
module event_camera_pixel_emulator_unit #(
    parameter int MAX_PIXELS          = 65536,
    parameter int ACCUM_FRACTION_BITS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ecpe_pkg::PIX_W-1:0]      pixel,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ecpe_pkg::IDX_W-1:0]      pixel_index,
    output logic                            brightness_spike,
    output logic                            on_event,
    output logic                            off_event,
    output logic                            last_of_frame,
    input  logic                            cfg_write,
    input  logic [ecpe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ecpe_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int POS_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int SZ_W  = (POS_W + 1 > ecpe_pkg::FRM_W) ? POS_W + 1 : ecpe_pkg::FRM_W;
    localparam int ACC_W = ecpe_pkg::ACC_INT_W + ACCUM_FRACTION_BITS;
    localparam int PIX_W = ecpe_pkg::PIX_W;

    logic [ecpe_pkg::BTH_W-1:0] bth_reg;
    logic [ecpe_pkg::CTH_W-1:0] cth_reg;
    logic [ecpe_pkg::FRM_W-1:0] frm_reg;

    logic [POS_W-1:0] pos_reg;
    logic             first_reg;
    logic [SZ_W-1:0]  frm_ext;
    logic [SZ_W-1:0]  size_eff;
    logic             last_in;
    logic             accept;
    logic             adv;

    logic             clr_active_reg;
    logic [POS_W-1:0] clr_addr_reg;

    logic [ACC_W-1:0] acc_mem [MAX_PIXELS];
    logic [PIX_W-1:0] lvl_mem [MAX_PIXELS];
    logic [ACC_W-1:0] acc_rd_reg;
    logic [PIX_W-1:0] lvl_rd_reg;

    logic             v1_reg;
    logic [PIX_W-1:0] pix1_reg;
    logic [POS_W-1:0] slot1_reg;
    logic             last1_reg;
    logic             first1_reg;

    logic             v2_reg;
    logic [PIX_W-1:0] pix2_reg;
    logic [POS_W-1:0] slot2_reg;
    logic             last2_reg;
    logic             first2_reg;
    logic [ACC_W-1:0] acc2_reg;
    logic [PIX_W-1:0] lvl2_reg;
    logic [ACC_W-1:0] acc2_next;
    logic [PIX_W-1:0] lvl2_next;

    logic             wb_valid_reg;
    logic [POS_W-1:0] wb_slot_reg;
    logic [ACC_W-1:0] wb_acc_reg;
    logic [PIX_W-1:0] wb_lvl_reg;

    logic [ACC_W-1:0] acc_cur;
    logic [PIX_W-1:0] lvl_cur;
    logic [ACC_W-1:0] acc_new;
    logic [PIX_W-1:0] lvl_new;
    ecpe_pkg::evt_t   evt_new;
    ecpe_pkg::res_t   res_next;

    logic             out_valid_reg;
    logic             skid_full_reg;
    ecpe_pkg::res_t   out_reg;
    ecpe_pkg::res_t   skid_reg;

    assign adv      = !skid_full_reg;
    assign in_stall = skid_full_reg || clr_active_reg;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bth_reg <= ecpe_pkg::BTH_RST;
            cth_reg <= ecpe_pkg::CTH_RST;
            frm_reg <= ecpe_pkg::FRM_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ecpe_pkg::CFG_BRIGHT_THR: bth_reg <= cfg_data[ecpe_pkg::BTH_W-1:0];
                ecpe_pkg::CFG_CHANGE_THR: cth_reg <= cfg_data[ecpe_pkg::CTH_W-1:0];
                ecpe_pkg::CFG_FRAME_PIX:  frm_reg <= cfg_data[ecpe_pkg::FRM_W-1:0];
                default:                  ;
            endcase
        end
    end

    assign frm_ext  = SZ_W'(frm_reg);
    assign size_eff = (frm_reg == '0 || frm_ext > SZ_W'(MAX_PIXELS)) ?
                      SZ_W'(MAX_PIXELS) : frm_ext;
    assign last_in  = (SZ_W'(pos_reg) + SZ_W'(1)) >= size_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            first_reg <= 1'b1;
        end
        else if (accept)
        begin
            if (last_in)
            begin
                pos_reg   <= '0;
                first_reg <= 1'b0;
            end
            else
            begin
                pos_reg <= pos_reg + POS_W'(1);
            end
        end
    end

    // zero the accumulator store after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            if (clr_addr_reg == POS_W'(MAX_PIXELS - 1))
            begin
                clr_active_reg <= 1'b0;
            end
            else
            begin
                clr_addr_reg <= clr_addr_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            acc_rd_reg <= acc_mem[pos_reg];
            lvl_rd_reg <= lvl_mem[pos_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            acc_mem[clr_addr_reg] <= '0;
        end
        else if (adv && v2_reg)
        begin
            acc_mem[slot2_reg] <= acc_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && v2_reg)
        begin
            lvl_mem[slot2_reg] <= lvl_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            wb_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            if (v2_reg)
            begin
                wb_valid_reg <= 1'b1;
            end
        end
    end

    // patch the read with the write that landed on the same edge
    assign acc2_next = (wb_valid_reg && wb_slot_reg == slot1_reg) ? wb_acc_reg : acc_rd_reg;
    assign lvl2_next = (wb_valid_reg && wb_slot_reg == slot1_reg) ? wb_lvl_reg : lvl_rd_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pix1_reg   <= pixel;
            slot1_reg  <= pos_reg;
            last1_reg  <= last_in;
            first1_reg <= first_reg;

            pix2_reg   <= pix1_reg;
            slot2_reg  <= slot1_reg;
            last2_reg  <= last1_reg;
            first2_reg <= first1_reg;
            acc2_reg   <= acc2_next;
            lvl2_reg   <= lvl2_next;

            if (v2_reg)
            begin
                wb_slot_reg <= slot2_reg;
                wb_acc_reg  <= acc_new;
                wb_lvl_reg  <= lvl_new;
            end
        end
    end

    // forward the previous word's result for back-to-back hits on one pixel
    assign acc_cur = (wb_valid_reg && wb_slot_reg == slot2_reg) ? wb_acc_reg : acc2_reg;
    assign lvl_cur = (wb_valid_reg && wb_slot_reg == slot2_reg) ? wb_lvl_reg : lvl2_reg;

    ecpe_update #(
        .ACC_W  (ACC_W),
        .FRAC_W (ACCUM_FRACTION_BITS)
    ) u_update (
        .pixel   (pix2_reg),
        .acc_in  (acc_cur),
        .lvl_in  (lvl_cur),
        .first   (first2_reg),
        .bth     (bth_reg),
        .cth     (cth_reg),
        .acc_out (acc_new),
        .lvl_out (lvl_new),
        .evt     (evt_new)
    );

    always_comb
    begin
        res_next.index = ecpe_pkg::IDX_W'(slot2_reg);
        res_next.evt   = evt_new;
        res_next.last  = last2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (skid_full_reg)
        begin
            if (!out_stall)
            begin
                skid_full_reg <= 1'b0;
            end
        end
        else if (v2_reg)
        begin
            if (!out_valid_reg || !out_stall)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_full_reg <= 1'b1;
            end
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_full_reg)
        begin
            if (!out_stall)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (v2_reg)
        begin
            if (!out_valid_reg || !out_stall)
            begin
                out_reg <= res_next;
            end
            else
            begin
                skid_reg <= res_next;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign pixel_index      = out_reg.index;
    assign brightness_spike = out_reg.evt.spike;
    assign on_event         = out_reg.evt.on;
    assign off_event        = out_reg.evt.off;
    assign last_of_frame    = out_reg.last;

    a_skid_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> out_valid_reg)
        else $error("skid holds a word while the output register is empty");

    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> (!v1_reg && !v2_reg && !wb_valid_reg))
        else $error("pixel in flight during the clearing pass");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_in) |=> (pos_reg == '0 && !first_reg))
        else $error("position did not wrap at end of frame");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && v2_reg) |=> out_valid_reg)
        else $error("result leaving the pipeline was dropped");

endmodule

[test/pixel_event_checker.sv]
`timescale 1ns / 100ps

module pixel_event_checker #(
    parameter int MAX_PIXELS          = 65536,
    parameter int ACCUM_FRACTION_BITS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [ecpe_pkg::PIX_W-1:0]      pixel,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [ecpe_pkg::IDX_W-1:0]      pixel_index,
    input  logic                            brightness_spike,
    input  logic                            on_event,
    input  logic                            off_event,
    input  logic                            last_of_frame,
    input  logic                            cfg_write,
    input  logic [ecpe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ecpe_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              failures,
    output int                              pending
);

    localparam int PIX_W      = ecpe_pkg::PIX_W;
    localparam int IDX_W      = ecpe_pkg::IDX_W;
    localparam int FRM_W      = ecpe_pkg::FRM_W;
    localparam int ACC_W      = ecpe_pkg::ACC_INT_W + ACCUM_FRACTION_BITS;
    localparam int WORD_DEPTH = 64;
    localparam logic [ACC_W:0] ACC_MAX = {1'b0, {ACC_W{1'b1}}};

    logic [ACC_W-1:0]           accum_mem [MAX_PIXELS];
    logic [PIX_W-1:0]           level_mem [MAX_PIXELS];
    logic [IDX_W-1:0]           position;
    logic                       first_frame;
    logic [ecpe_pkg::BTH_W-1:0] bright_thr;
    logic [ecpe_pkg::CTH_W-1:0] change_thr;
    logic [FRM_W-1:0]           frame_cfg;
    ecpe_pkg::res_t             expected_words [WORD_DEPTH];
    int                         wr_count;
    int                         rd_count;
    int                         errs;

    function automatic ecpe_pkg::res_t predict_events(input logic [PIX_W-1:0] pix);
        ecpe_pkg::res_t   r;
        logic [FRM_W-1:0] size;
        logic [ACC_W:0]   sum;
        logic [PIX_W:0]   up;
        logic [PIX_W-1:0] lvl;
        logic             last;
        r = '0;
        size = (frame_cfg == '0 || frame_cfg > FRM_W'(MAX_PIXELS)) ?
               FRM_W'(MAX_PIXELS) : frame_cfg;
        last = ({1'b0, position} + FRM_W'(1)) >= size;

        sum = {1'b0, accum_mem[position]} + ((ACC_W + 1)'(pix) << ACCUM_FRACTION_BITS);
        if (sum > ACC_MAX)
            sum = ACC_MAX;
        if (sum >= (ACC_W + 1)'(bright_thr))
        begin
            r.evt.spike = 1'b1;
            sum = sum - (ACC_W + 1)'(bright_thr);
        end
        accum_mem[position] = sum[ACC_W-1:0];

        if (first_frame)
            level_mem[position] = pix;
        else
        begin
            lvl = level_mem[position];
            up = {1'b0, lvl} + (PIX_W + 1)'(change_thr);
            if ({1'b0, pix} >= up)
            begin
                r.evt.on = 1'b1;
                level_mem[position] = up[PIX_W-1:0];
            end
            else if (lvl >= PIX_W'(change_thr) && pix <= lvl - PIX_W'(change_thr))
            begin
                r.evt.off = 1'b1;
                level_mem[position] = lvl - PIX_W'(change_thr);
            end
        end

        r.index = position;
        r.last = last;
        if (last)
        begin
            position = '0;
            first_frame = 1'b0;
        end
        else
            position = position + IDX_W'(1);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ecpe_pkg::res_t got;
        ecpe_pkg::res_t want;
        if (!rst_n)
        begin
            foreach (accum_mem[i])
                accum_mem[i] = '0;
            position = '0;
            first_frame = 1'b1;
            bright_thr = ecpe_pkg::BTH_RST;
            change_thr = ecpe_pkg::CTH_RST;
            frame_cfg = ecpe_pkg::FRM_RST;
            wr_count = 0;
            rd_count = 0;
            errs = 0;
            failures <= 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.index = pixel_index;
                got.evt.spike = brightness_spike;
                got.evt.on = on_event;
                got.evt.off = off_event;
                got.last = last_of_frame;
                if (wr_count == rd_count)
                begin
                    errs++;
                    if (errs <= 10)
                        $display("unexpected event word: index %0d spike %b on %b off %b last %b",
                                 got.index, got.evt.spike, got.evt.on, got.evt.off, got.last);
                end
                else
                begin
                    want = expected_words[rd_count % WORD_DEPTH];
                    rd_count++;
                    if (got.index !== want.index || got.evt.spike !== want.evt.spike ||
                        got.evt.on !== want.evt.on || got.evt.off !== want.evt.off ||
                        got.last !== want.last)
                    begin
                        errs++;
                        if (errs <= 10)
                            $display({"event word mismatch: expected index %0d spike %b on %b ",
                                      "off %b last %b, got index %0d spike %b on %b off %b last %b"},
                                     want.index, want.evt.spike, want.evt.on, want.evt.off,
                                     want.last, got.index, got.evt.spike, got.evt.on,
                                     got.evt.off, got.last);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                expected_words[wr_count % WORD_DEPTH] = predict_events(pixel);
                wr_count++;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    ecpe_pkg::CFG_BRIGHT_THR: bright_thr = cfg_data[ecpe_pkg::BTH_W-1:0];
                    ecpe_pkg::CFG_CHANGE_THR: change_thr = cfg_data[ecpe_pkg::CTH_W-1:0];
                    ecpe_pkg::CFG_FRAME_PIX:  frame_cfg = cfg_data[FRM_W-1:0];
                    default: ;
                endcase
            end
            failures <= errs;
            pending <= wr_count - rd_count;
        end
    end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    localparam int MAX_PIXELS          = 65536;
    localparam int ACCUM_FRACTION_BITS = 8;
    localparam int PIX_W               = ecpe_pkg::PIX_W;
    localparam int IDX_W               = ecpe_pkg::IDX_W;
    localparam int BTH_W               = ecpe_pkg::BTH_W;
    localparam int CTH_W               = ecpe_pkg::CTH_W;
    localparam int FRM_W               = ecpe_pkg::FRM_W;
    localparam int CFG_IDX_W           = ecpe_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W          = ecpe_pkg::CFG_DATA_W;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned FIRST_FRAME  = 330;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [PIX_W-1:0]      pixel;
    logic                  out_valid;
    logic                  out_stall;
    logic [IDX_W-1:0]      pixel_index;
    logic                  brightness_spike;
    logic                  on_event;
    logic                  off_event;
    logic                  last_of_frame;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    failures;
    int                    pending;

    int unsigned cycle_count = 0;
    int unsigned pixels_sent = 0;
    int unsigned hold_requests = 0;
    int unsigned holds_done = 0;
    bit          fast_drain = 1'b0;

    always #5 clk = ~clk;

    event_camera_pixel_emulator_unit #(
        .MAX_PIXELS          (MAX_PIXELS),
        .ACCUM_FRACTION_BITS (ACCUM_FRACTION_BITS)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .pixel            (pixel),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .pixel_index      (pixel_index),
        .brightness_spike (brightness_spike),
        .on_event         (on_event),
        .off_event        (off_event),
        .last_of_frame    (last_of_frame),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    pixel_event_checker #(
        .MAX_PIXELS          (MAX_PIXELS),
        .ACCUM_FRACTION_BITS (ACCUM_FRACTION_BITS)
    ) u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .pixel            (pixel),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .pixel_index      (pixel_index),
        .brightness_spike (brightness_spike),
        .on_event         (on_event),
        .off_event        (off_event),
        .last_of_frame    (last_of_frame),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .failures         (failures),
        .pending          (pending)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned stall_cycles;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (holds_done != hold_requests)
            begin
                holds_done++;
                stall_cycles = LONG_HOLD;
            end
            else if (fast_drain)
                stall_cycles = 0;
            else
                stall_cycles = $urandom_range(0, 19);
            @(negedge clk);
            if (stall_cycles != 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_cycles) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    function automatic logic [PIX_W-1:0] draw_pixel(input bit bright);
        if (bright && $urandom_range(0, 9) != 0)
            return 8'hFF;
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] value, input int unsigned gap);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        pixel <= value;
        do @(posedge clk); while (!(in_valid && !in_stall));
        pixels_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic run_phase(input logic [BTH_W-1:0] bright_thr,
                             input logic [CTH_W-1:0] change_thr,
                             input logic [FRM_W-1:0] frame_size,
                             input int unsigned count,
                             input bit burst,
                             input bit bright,
                             input bit pressure);
        int unsigned gap;
        wait_drained();
        write_reg(ecpe_pkg::CFG_BRIGHT_THR, CFG_DATA_W'(bright_thr));
        write_reg(ecpe_pkg::CFG_CHANGE_THR, CFG_DATA_W'(change_thr));
        write_reg(ecpe_pkg::CFG_FRAME_PIX, CFG_DATA_W'(frame_size));
        fast_drain = burst;
        for (int i = 0; i < count; i++)
        begin
            if (pressure && i == 100)
                hold_requests++;
            if (pressure && i == 200)
                wait_drained();
            gap = (burst || (pressure && i >= 100 && i < 140)) ? 0 : $urandom_range(0, 19);
            send_pixel(draw_pixel(bright), gap);
        end
        fast_drain = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        pixel = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // first frame: zero threshold fires on every word, size of zero acts as full
        write_reg(ecpe_pkg::CFG_BRIGHT_THR, '0);
        write_reg(ecpe_pkg::CFG_FRAME_PIX, '0);
        write_reg(CFG_UNUSED, '1);
        send_pixel(8'h00, $urandom_range(0, 19));
        send_pixel(8'hFF, $urandom_range(0, 19));
        send_pixel(8'h55, $urandom_range(0, 19));
        send_pixel(8'hAA, $urandom_range(0, 19));

        wait_drained();
        write_reg(ecpe_pkg::CFG_BRIGHT_THR, '1);
        write_reg(ecpe_pkg::CFG_CHANGE_THR, '0);
        write_reg(ecpe_pkg::CFG_FRAME_PIX, CFG_DATA_W'(17'h1FFFF));
        send_pixel(8'hFF, $urandom_range(0, 19));
        send_pixel(8'h00, $urandom_range(0, 19));
        send_pixel(8'h01, $urandom_range(0, 19));
        send_pixel(8'h80, $urandom_range(0, 19));

        wait_drained();
        write_reg(ecpe_pkg::CFG_BRIGHT_THR, CFG_DATA_W'(1));
        write_reg(ecpe_pkg::CFG_CHANGE_THR, CFG_DATA_W'(127));
        write_reg(ecpe_pkg::CFG_FRAME_PIX, CFG_DATA_W'(ecpe_pkg::FRM_RST));
        send_pixel(8'hFE, $urandom_range(0, 19));
        send_pixel(8'h7F, $urandom_range(0, 19));

        // close the first frame at full rate; full-size frames later stay below its end
        run_phase(24'($urandom_range(256, 'h1FFFF)), 7'd16, FRM_W'(FIRST_FRAME),
                  FIRST_FRAME - pixels_sent, 1'b1, 1'b0, 1'b0);

        run_phase(24'($urandom_range(256, 'h1FFFF)), 7'd16, 17'd300, 150, 1'b0, 1'b0, 1'b0);
        run_phase('0, '0, 17'd7, 100, 1'b0, 1'b0, 1'b0);
        run_phase(24'd1, 7'd127, 17'd1, 60, 1'b0, 1'b0, 1'b0);
        run_phase('1, 7'd1, 17'd1, 150, 1'b0, 1'b1, 1'b0);
        run_phase(24'($urandom_range(256, 'hFFFF)), 7'($urandom_range(1, 127)),
                  ecpe_pkg::FRM_RST, 120, 1'b1, 1'b0, 1'b0);
        run_phase(24'($urandom_range(256, 'hFFFF)), 7'($urandom_range(1, 127)), '0,
                  100, 1'b0, 1'b0, 1'b0);
        run_phase(24'($urandom_range(256, 'hFFFF)), 7'($urandom_range(1, 127)), '1,
                  100, 1'b0, 1'b0, 1'b0);
        run_phase(24'($urandom_range(1, 'hFFFF)), 7'($urandom_range(1, 40)),
                  17'($urandom_range(2, 128)), 250, 1'b0, 1'b0, 1'b1);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/ecpe_pkg.sv
hw/rtl/ecpe_update.sv
hw/rtl/event_camera_pixel_emulator_unit.sv
test/pixel_event_checker.sv
test/tb_top.sv
